// ===== sv/aob_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package aob_pkg;

    // Lane select inside the divider pipeline
    typedef logic [1:0] t_lane;

    // Three colour lanes run through the divider; opacity rides beside them
    localparam int NUM_COLORS = 3;

    localparam t_lane LANE_RED   = 2'd0;
    localparam t_lane LANE_GREEN = 2'd1;
    localparam t_lane LANE_BLUE  = 2'd2;
    localparam t_lane LANE_ALPHA = 2'd3;

endpackage : aob_pkg

`default_nettype wire

// ===== sv/alpha_over_blend.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                  Payload
// -------   ---  -------------------------  ----------------------------------------------
// s_axis    in   tvalid / tready            tdata: fg r,g,b,a then bg r,g,b,a (W bits each)
// m_axis    out  tvalid / tready            tdata: out r,g,b,a (W bits each), tuser: flag
//
// One pixel transfer per clock, sustained while the output is ready. There is one
// product stage, one numerator stage, then a restoring divider that resolves one
// quotient bit per stage for the three colours; the opacity quotient comes from a
// shift and add in the numerator stage and rides alongside.
// Synchronous active-low reset clears only the valid bits of the stages.
// Every stage has its own ready, so bubbles close up under a downstream stall and a
// held stage keeps its contents; nothing is dropped or repeated.

module alpha_over_blend #(
    parameter int  CHANNEL_BITS = 8,
    localparam int OUT_W        = ((4 * CHANNEL_BITS + 7) / 8) * 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // slave side
    input  wire logic                      i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // fg_red, fg_green, fg_blue, fg_alpha, bg_red, bg_green, bg_blue, bg_alpha
    input  wire logic [8*CHANNEL_BITS-1:0] i_s_axis_tdata,
    // master side
    output logic                           o_m_axis_tvalid,
    input  wire logic                      i_m_axis_tready,
    // out_red, out_green, out_blue, out_alpha, zero pad
    output logic [OUT_W-1:0]               o_m_axis_tdata,
    // transparent_flag
    output logic [0:0]                     o_m_axis_tuser
);

    import aob_pkg::*;

    localparam int W  = CHANNEL_BITS;
    localparam int AW = 2 * CHANNEL_BITS;
    localparam int SW = AW + 1;
    localparam int NW = 3 * CHANNEL_BITS;

    localparam logic [W-1:0]  CH_MAX = {W{1'b1}};
    localparam logic [AW-1:0] MAX_SQ = AW'(CH_MAX) * AW'(CH_MAX);

    // Stage 1: products
    logic                  r1_v;
    logic [AW-1:0]         r1_pf [NUM_COLORS];
    logic [AW-1:0]         r1_pb [NUM_COLORS];
    logic [W-1:0]          r1_nfa;
    logic [AW-1:0]         r1_a;

    // Stage 2: numerators
    logic                  r2_v;
    logic [NW-1:0]         r2_num [NUM_COLORS];
    logic [AW-1:0]         r2_a;
    logic [W-1:0]          r2_aq;

    // Divider stages, one quotient bit each
    logic [W-1:0]          r_dv;
    logic [NW-1:0]         r_rem [W-1][NUM_COLORS];
    logic [W-1:0]          r_q   [W][NUM_COLORS];
    logic [W-1:0]          r_aq  [W];
    logic [AW-1:0]         r_da  [W];

    logic [NW-1:0]         n_rem [W-1][NUM_COLORS];
    logic [W-1:0]          n_q   [W][NUM_COLORS];
    logic [W-1:0]          n_aq  [W];
    logic [AW-1:0]         n_da  [W];
    logic [W-1:0]          n_dv;

    logic [W-1:0]          w_rdy_d;
    logic                  w_rdy1;
    logic                  w_rdy2;
    logic                  w_flag;
    logic [W-1:0]          w_fa;
    logic [W-1:0]          w_ba;

    // Per-stage ready chain from the output back to the input
    always_comb begin
        w_rdy_d[W-1] = ~r_dv[W-1] | i_m_axis_tready;
        for (int j = W - 2; j >= 0; j--) begin
            w_rdy_d[j] = ~r_dv[j] | w_rdy_d[j+1];
        end
        w_rdy2 = ~r2_v | w_rdy_d[0];
        w_rdy1 = ~r1_v | w_rdy2;
    end

    assign o_s_axis_tready = w_rdy1;

    assign w_fa = i_s_axis_tdata[3*W +: W];
    assign w_ba = i_s_axis_tdata[7*W +: W];

    // Stage 1: fg and bg weighted colours, composite opacity scaled by M*M
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_rdy1) begin
            r1_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            for (int l = 0; l < NUM_COLORS; l++) begin
                r1_pf[l] <= AW'(i_s_axis_tdata[l*W +: W]) * AW'(w_fa);
                r1_pb[l] <= AW'(i_s_axis_tdata[(4+l)*W +: W]) * AW'(w_ba);
            end
            r1_nfa <= CH_MAX - w_fa;
            r1_a   <= MAX_SQ - AW'(CH_MAX - w_fa) * AW'(CH_MAX - w_ba);
        end
    end

    // Stage 2: num = pf*M + pb*(M-fa); pf*M done as shift and subtract
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_rdy2) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            for (int l = 0; l < NUM_COLORS; l++) begin
                r2_num[l] <= (NW'(r1_pf[l]) << W) - NW'(r1_pf[l])
                           + NW'(r1_pb[l]) * NW'(r1_nfa);
            end
            r2_a  <= r1_a;
            // floor(A/M) as (A + (A >> W) + 1) >> W, exact for A up to M*M
            r2_aq <= W'((SW'(r1_a) + SW'(r1_a >> W) + SW'(1)) >> W);
        end
    end

    // Restoring divider: stage j resolves quotient bit W-1-j.
    // Colour lanes divide by A; the opacity quotient is carried along.
    always_comb begin
        logic [NW-1:0] v_src;
        logic [NW-1:0] v_sub;
        logic [W-1:0]  v_q;
        logic [AW-1:0] v_da;
        n_dv = {r_dv[W-2:0], r2_v};
        for (int j = 0; j < W; j++) begin
            v_da    = (j == 0) ? r2_a : r_da[j-1];
            n_da[j] = v_da;
            n_aq[j] = (j == 0) ? r2_aq : r_aq[j-1];
            for (int l = 0; l < NUM_COLORS; l++) begin
                if (j == 0) begin
                    v_src = r2_num[l];
                    v_q   = '0;
                end else begin
                    v_src = r_rem[j-1][l];
                    v_q   = r_q[j-1][l];
                end
                v_sub = NW'(v_da) << (W - 1 - j);
                if (v_src >= v_sub) begin
                    v_q[W-1-j] = 1'b1;
                    v_src      = v_src - v_sub;
                end
                n_q[j][l] = v_q;
                if (j < W - 1) begin
                    n_rem[j][l] = v_src;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else begin
            for (int j = 0; j < W; j++) begin
                if (w_rdy_d[j]) begin
                    r_dv[j] <= n_dv[j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < W; j++) begin
            if (w_rdy_d[j]) begin
                r_da[j] <= n_da[j];
                r_aq[j] <= n_aq[j];
                for (int l = 0; l < NUM_COLORS; l++) begin
                    r_q[j][l] <= n_q[j][l];
                    if (j < W - 1) begin
                        r_rem[j][l] <= n_rem[j][l];
                    end
                end
            end
        end
    end

    // Output: zero colour when both alphas are zero
    assign w_flag = (r_da[W-1] == '0);

    assign o_m_axis_tvalid   = r_dv[W-1];
    assign o_m_axis_tuser[0] = w_flag;
    always_comb begin
        o_m_axis_tdata = '0;
        o_m_axis_tdata[LANE_RED*W   +: W] = w_flag ? '0 : r_q[W-1][LANE_RED];
        o_m_axis_tdata[LANE_GREEN*W +: W] = w_flag ? '0 : r_q[W-1][LANE_GREEN];
        o_m_axis_tdata[LANE_BLUE*W  +: W] = w_flag ? '0 : r_q[W-1][LANE_BLUE];
        o_m_axis_tdata[LANE_ALPHA*W +: W] = r_aq[W-1];
    end

    // Transparent pixel must come out with zero opacity
    a_flag_alpha_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata[LANE_ALPHA*W +: W] == '0)
        else $error("transparent pixel with nonzero opacity");

    // Any nonzero composite opacity is at least M, so its quotient is at least one
    a_opaque_alpha_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata[LANE_ALPHA*W +: W] != '0)
        else $error("nontransparent pixel with zero opacity");

    // An accepted transfer reaches stage 1
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r1_v)
        else $error("accepted transfer lost at stage 1");

    // A stalled numerator stage keeps its item
    a_stage2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_v && !w_rdy_d[0] |=> r2_v && $stable(r2_a))
        else $error("stage 2 changed under stall");

endmodule : alpha_over_blend

`default_nettype wire

// ===== bench/tb_alpha_over_blend.sv =====
`timescale 1ns / 1ps

module tb_alpha_over_blend;

    import aob_pkg::*;

    localparam int CW          = 8;
    localparam int IN_W        = 8 * CW;
    localparam int OUT_W       = ((4 * CW + 7) / 8) * 8;
    localparam int LATENCY     = CW + 2;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int LONG_HOLD   = 300;
    localparam int MAX_LINES   = 60;
    localparam longint unsigned FULL = (64'd1 << CW) - 64'd1;

    // Expected output of one pixel
    typedef struct {
        logic [CW-1:0] red;
        logic [CW-1:0] green;
        logic [CW-1:0] blue;
        logic [CW-1:0] alpha;
        logic          flag;
    } blend_result_t;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tready = 1'b0;
    logic             o_s_axis_tready;
    logic             o_m_axis_tvalid;
    logic [OUT_W-1:0] o_m_axis_tdata;
    logic [0:0]       o_m_axis_tuser;

    blend_result_t pending_pixels[$];
    int            error_count     = 0;
    bit            send_gaps_on    = 1'b1;
    bit            ready_stalls_on = 1'b1;
    int            hold_off_cycles = 0;

    alpha_over_blend #(
        .CHANNEL_BITS(CW)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        // fg_red, fg_green, fg_blue, fg_alpha, bg_red, bg_green, bg_blue, bg_alpha
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_tready),
        // out_red, out_green, out_blue, out_alpha
        .o_m_axis_tdata (o_m_axis_tdata),
        // transparent_flag
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Straight-alpha "over": opacity sum scaled by FULL*FULL, colors divided by it
    function automatic blend_result_t blend_pixel(input logic [IN_W-1:0] px);
        blend_result_t    res;
        longint unsigned  fc[NUM_COLORS];
        longint unsigned  bc[NUM_COLORS];
        longint unsigned  fa;
        longint unsigned  ba;
        longint unsigned  a_sum;
        longint unsigned  num;
        longint unsigned  q[NUM_COLORS];
        for (int k = 0; k < NUM_COLORS; k++) begin
            fc[k] = 64'(px[k*CW +: CW]);
            bc[k] = 64'(px[(k+4)*CW +: CW]);
        end
        fa    = 64'(px[3*CW +: CW]);
        ba    = 64'(px[7*CW +: CW]);
        a_sum = FULL * FULL - (FULL - fa) * (FULL - ba);
        if (a_sum == 64'd0) begin
            // both layers fully transparent: color undefined, flag it
            res.red   = '0;
            res.green = '0;
            res.blue  = '0;
            res.alpha = '0;
            res.flag  = 1'b1;
            return res;
        end
        for (int k = 0; k < NUM_COLORS; k++) begin
            num  = fc[k] * fa * FULL + bc[k] * ba * (FULL - fa);
            q[k] = num / a_sum;
            if (q[k] > FULL)
                q[k] = FULL;
        end
        res.red   = q[LANE_RED][CW-1:0];
        res.green = q[LANE_GREEN][CW-1:0];
        res.blue  = q[LANE_BLUE][CW-1:0];
        res.alpha = CW'(a_sum / FULL);
        res.flag  = 1'b0;
        return res;
    endfunction

    function automatic logic [IN_W-1:0] pack_pixel(
        input logic [CW-1:0] fr, fg, fb, fa, br, bg, bb, ba
    );
        return {ba, bb, bg, br, fa, fb, fg, fr};
    endfunction

    // Alphas lean toward the edges, where the arithmetic is touchiest
    function automatic logic [CW-1:0] rand_alpha();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CW'(FULL);
            2:       return CW'($urandom_range(1, 3));
            3:       return CW'(FULL - $urandom_range(1, 3));
            default: return CW'($urandom_range(0, int'(FULL)));
        endcase
    endfunction

    function automatic logic [CW-1:0] rand_color();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CW'(FULL);
            default: return CW'($urandom_range(0, int'(FULL)));
        endcase
    endfunction

    function automatic logic [IN_W-1:0] rand_pixel();
        return pack_pixel(rand_color(), rand_color(), rand_color(), rand_alpha(),
                          rand_color(), rand_color(), rand_color(), rand_alpha());
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_LINES)
            $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [CW-1:0] got,
                               input logic [CW-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Scoreboard: predict on input transfer, compare on output transfer
    always @(posedge clk) begin : scoreboard
        blend_result_t want;
        if (rst_n) begin
            if (s_tvalid && o_s_axis_tready === 1'b1)
                pending_pixels.push_back(blend_pixel(s_tdata));
            if (o_m_axis_tvalid === 1'b1 && m_tready) begin
                if (pending_pixels.size() == 0) begin
                    report_mismatch("output transfer with no pixel pending");
                end else begin
                    want = pending_pixels.pop_front();
                    check_field("out_red",   o_m_axis_tdata[LANE_RED*CW +: CW],   want.red);
                    check_field("out_green", o_m_axis_tdata[LANE_GREEN*CW +: CW], want.green);
                    check_field("out_blue",  o_m_axis_tdata[LANE_BLUE*CW +: CW],  want.blue);
                    check_field("out_alpha", o_m_axis_tdata[LANE_ALPHA*CW +: CW], want.alpha);
                    check_field("transparent_flag", CW'(o_m_axis_tuser), CW'(want.flag));
                end
            end
        end
    end

    // Receiver: random stall per result, or one long hold when requested
    initial begin : ready_driver
        int n;
        forever begin
            if (hold_off_cycles > 0) begin
                n               = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                n = ready_stalls_on ? $urandom_range(0, 7) : 0;
            end
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(rst_n && o_m_axis_tvalid === 1'b1 && m_tready));
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_alpha_over_blend: done, errors");
        $finish;
    end

    // One input transfer, after a random gap when gaps are on
    task automatic send_pixel(input logic [IN_W-1:0] px);
        int gap;
        gap = send_gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge clk); while (o_s_axis_tready !== 1'b1);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_corner_pixels();
        localparam logic [CW-1:0] Z = '0;
        localparam logic [CW-1:0] F = CW'(FULL);
        localparam logic [CW-1:0] U = CW'(1);
        localparam logic [CW-1:0] G = CW'(FULL - 64'd1);
        localparam logic [CW-1:0] A = {(CW/2){2'b10}};
        localparam logic [CW-1:0] P = {(CW/2){2'b01}};
        send_gaps_on    = 1'b1;
        ready_stalls_on = 1'b1;
        // both alphas zero, with and without color content
        send_pixel(pack_pixel(Z, Z, Z, Z, Z, Z, Z, Z));
        send_pixel(pack_pixel(F, F, F, Z, F, F, F, Z));
        send_pixel(pack_pixel(A, P, F, Z, P, A, Z, Z));
        // everything at full scale
        send_pixel(pack_pixel(F, F, F, F, F, F, F, F));
        // opaque foreground hides background
        send_pixel(pack_pixel(A, P, Z, F, F, F, F, F));
        send_pixel(pack_pixel(F, Z, A, F, P, A, F, Z));
        // clear foreground shows background
        send_pixel(pack_pixel(F, F, F, Z, A, P, Z, F));
        send_pixel(pack_pixel(A, A, A, Z, P, F, Z, U));
        // near-edge alphas: barely visible or just short of opaque
        send_pixel(pack_pixel(F, Z, A, U, Z, F, P, Z));
        send_pixel(pack_pixel(F, Z, F, U, Z, F, Z, U));
        send_pixel(pack_pixel(F, F, F, G, Z, Z, Z, F));
        send_pixel(pack_pixel(Z, Z, Z, U, F, F, F, G));
        // alternating bit patterns, also as alphas
        send_pixel(pack_pixel(A, A, A, A, P, P, P, P));
        send_pixel(pack_pixel(P, P, P, P, A, A, A, A));
        send_pixel(pack_pixel(F, Z, F, A, Z, F, Z, A));
        // colors full, zero or mixed, alphas patterned or full
        send_pixel(pack_pixel(F, F, F, P, F, F, F, A));
        send_pixel(pack_pixel(Z, Z, Z, F, Z, Z, Z, F));
        send_pixel(pack_pixel(Z, F, Z, A, F, Z, F, F));
        wait_drain();
    endtask

    task automatic test_random_idling();
        send_gaps_on    = 1'b1;
        ready_stalls_on = 1'b1;
        repeat (800) send_pixel(rand_pixel());
        wait_drain();
    endtask

    task automatic test_back_to_back();
        send_gaps_on    = 1'b0;
        ready_stalls_on = 1'b0;
        repeat (150) send_pixel(rand_pixel());
        wait_drain();
    endtask

    // Long receiver hold while the sender keeps offering: pipeline fills and stalls
    task automatic test_output_hold();
        send_gaps_on    = 1'b0;
        ready_stalls_on = 1'b1;
        hold_off_cycles = LONG_HOLD;
        repeat (150) send_pixel(rand_pixel());
        wait_drain();
    endtask

    // Sender stops until every pending result is out, several times
    task automatic test_drain_pauses();
        send_gaps_on    = 1'b1;
        ready_stalls_on = 1'b1;
        repeat (4) begin
            repeat (25) send_pixel(rand_pixel());
            wait_drain();
        end
    endtask

    initial begin : main
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corner_pixels();
        test_random_idling();
        test_back_to_back();
        test_output_hold();
        test_drain_pauses();
        wait_drain();
        repeat (LATENCY + 8) @(posedge clk);
        if (pending_pixels.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_pixels.size()));
        if (error_count == 0)
            $display("tb_alpha_over_blend: done, clean");
        else
            $display("tb_alpha_over_blend: done, errors");
        $finish;
    end

endmodule
